// File: rtl/tlxs_pkg.sv
// ----------------------------------------------------------------------------
// tlxs_pkg
// Shared types and constants for the Thumb literal cross-reference scanner:
// request/result structs, decode opcodes and masks, register update kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package tlxs_pkg;

  // Address space width; positions, image size and target wrap to it
  localparam int ADDR_WIDTH = 32;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  // Number of tracked core registers
  localparam int NUM_REGS = 16;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE     = 1'b1;

  // Encoding patterns and their masks
  localparam logic [15:0] MSK_NARROW5  = 16'hF800;
  localparam logic [15:0] OP_MOVS_IMM8 = 16'h2000;
  localparam logic [15:0] OP_LDR_LIT_N = 16'h4800;
  localparam logic [15:0] MSK_MOV_W    = 16'hFBEF;
  localparam logic [15:0] OP_MOV_W     = 16'hF04F;
  localparam logic [15:0] MSK_MOVW_T   = 16'hFBF0;
  localparam logic [15:0] OP_MOVW      = 16'hF240;
  localparam logic [15:0] OP_MOVT      = 16'hF2C0;
  localparam logic [15:0] MSK_LDR_W    = 16'hFF7F;
  localparam logic [15:0] OP_LDR_LIT_W = 16'hF85F;
  localparam logic [15:0] MSK_ADD_HI   = 16'hFF00;
  localparam logic [15:0] OP_ADD_HI    = 16'h4400;
  localparam logic [15:0] MSK_ADD_W    = 16'hFFE0;
  localparam logic [15:0] OP_ADD_W     = 16'hEB00;
  localparam logic [7:0]  EXP_IMM_TOP  = 8'h80;
  localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

  // How the selected register changes
  typedef enum logic [1:0] {
    UPD_SET,
    UPD_OR,
    UPD_ADD
  } upd_mode_t;

  // One instruction request
  typedef struct packed {
    logic [15:0] first_halfword;
    logic [15:0] second_halfword;
    logic [31:0] position;
    logic [31:0] literal_word;
    logic        new_search;
  } in_item_t;

  // One result
  typedef struct packed {
    logic                 hit;
    logic [REG_IDX_W-1:0] hit_register;
    logic                 wide;
  } out_item_t;

  // Decoder to update-path control
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    upd_mode_t            mode;
    logic [31:0]          value;
    logic                 wide;
  } dec_t;

endpackage

`default_nettype wire

// File: rtl/tlxs_decode.sv
// ----------------------------------------------------------------------------
// tlxs_decode
// Decodes one Thumb/Thumb-2 instruction into a register update: which
// register, how it changes and the operand. Also does the literal range check.
// ----------------------------------------------------------------------------
`default_nettype none

module tlxs_decode (
  input  wire tlxs_pkg::in_item_t item,
  input  wire logic [31:0]        image_size,
  output tlxs_pkg::dec_t          dec
);

  logic [15:0] h0;
  logic [15:0] h1;
  logic        h1ok;
  logic [3:0]  rd2;
  logic [11:0] imm_t;
  logic [31:0] pos;
  logic [31:0] pc_val;
  logic [31:0] lit_base;
  logic [31:0] exp_imm;
  logic [15:0] imm16;
  logic        is_movs, is_mov_w, is_movw, is_ldr_n, is_ldr_w, is_movt;
  logic        is_add_hi, is_add_w;
  logic [34:0] off;
  logic [34:0] off_end;
  logic        lit_ok;
  logic [3:0]  add_hi_rd;

  // Rotate right, amount 0..31
  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // Thumb modified immediate
  function automatic logic [31:0] expand_imm(input logic [11:0] imm12);
    logic [7:0]  b;
    logic [31:0] res;
    b = imm12[7:0];
    if (imm12[11:10] == 2'b00) begin
      unique case (imm12[9:8])
        2'd0: res = {24'h0, b};
        2'd1: res = {8'h0, b, 8'h0, b};
        2'd2: res = {b, 8'h0, b, 8'h0};
        2'd3: res = {b, b, b, b};
        default: res = '0;
      endcase
    end else begin
      res = rotr32({24'h0, tlxs_pkg::EXP_IMM_TOP | {1'b0, imm12[6:0]}}, imm12[11:7]);
    end
    return res;
  endfunction

  // Field extraction
  assign h0        = item.first_halfword;
  assign h1        = item.second_halfword;
  assign h1ok      = ~h1[15];
  assign rd2       = h1[11:8];
  assign imm_t     = {h0[10], h1[14:12], h1[7:0]};
  assign imm16     = {h0[3:0], imm_t};
  assign pos       = item.position & tlxs_pkg::ADDR_MASK;
  assign pc_val    = pos + 32'd4;
  assign lit_base  = {pc_val[31:2], 2'b00};
  assign exp_imm   = expand_imm(imm_t);
  assign add_hi_rd = {h0[7], h0[2:0]};

  // Pattern matches
  assign is_movs   = (h0 & tlxs_pkg::MSK_NARROW5) == tlxs_pkg::OP_MOVS_IMM8;
  assign is_mov_w  = ((h0 & tlxs_pkg::MSK_MOV_W) == tlxs_pkg::OP_MOV_W) && h1ok;
  assign is_movw   = ((h0 & tlxs_pkg::MSK_MOVW_T) == tlxs_pkg::OP_MOVW) && h1ok;
  assign is_ldr_n  = (h0 & tlxs_pkg::MSK_NARROW5) == tlxs_pkg::OP_LDR_LIT_N;
  assign is_ldr_w  = (h0 & tlxs_pkg::MSK_LDR_W) == tlxs_pkg::OP_LDR_LIT_W;
  assign is_movt   = ((h0 & tlxs_pkg::MSK_MOVW_T) == tlxs_pkg::OP_MOVT) && h1ok;
  assign is_add_hi = ((h0 & tlxs_pkg::MSK_ADD_HI) == tlxs_pkg::OP_ADD_HI)
                     && (h0[6:3] == tlxs_pkg::REG_PC);
  assign is_add_w  = ((h0 & tlxs_pkg::MSK_ADD_W) == tlxs_pkg::OP_ADD_W)
                     && (h1[3:0] == tlxs_pkg::REG_PC) && (h0[3:0] == rd2);

  // Literal offset and range check (signed, 35 bits)
  always_comb begin
    if (is_ldr_n) begin
      off = {3'b000, lit_base} + {25'h0, h0[7:0], 2'b00};
    end else if (h0[7]) begin
      off = {3'b000, lit_base} + {23'h0, h1[11:0]};
    end else begin
      off = {3'b000, lit_base} - {23'h0, h1[11:0]};
    end
  end
  assign off_end = off + 35'd4;
  assign lit_ok  = ~off[34]
                   && (off_end <= {3'b000, image_size & tlxs_pkg::ADDR_MASK});

  // Update selection in decode priority order
  always_comb begin
    dec       = '0;
    dec.mode  = tlxs_pkg::UPD_SET;
    dec.wide  = (h0[15:13] == 3'b111) && (h0[12:11] != 2'b00);
    priority if (is_movs) begin
      dec.en    = 1'b1;
      dec.idx   = {1'b0, h0[10:8]};
      dec.value = {24'h0, h0[7:0]};
    end else if (is_mov_w) begin
      dec.en    = 1'b1;
      dec.idx   = rd2;
      dec.value = exp_imm;
    end else if (is_movw) begin
      dec.en    = 1'b1;
      dec.idx   = rd2;
      dec.value = {16'h0, imm16};
    end else if (is_ldr_n || is_ldr_w) begin
      dec.en    = lit_ok;
      dec.idx   = is_ldr_n ? {1'b0, h0[10:8]} : h1[15:12];
      dec.value = item.literal_word;
    end else if (is_movt) begin
      dec.en    = 1'b1;
      dec.idx   = rd2;
      dec.mode  = tlxs_pkg::UPD_OR;
      dec.value = {imm16, 16'h0};
    end else if (is_add_hi) begin
      dec.en    = 1'b1;
      dec.idx   = add_hi_rd;
      dec.mode  = tlxs_pkg::UPD_ADD;
      dec.value = pc_val;
    end else if (is_add_w) begin
      dec.en    = 1'b1;
      dec.idx   = rd2;
      dec.mode  = tlxs_pkg::UPD_ADD;
      dec.value = pc_val;
    end else begin
      dec.en    = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/thumb_literal_xref_scanner.sv
// ----------------------------------------------------------------------------
// thumb_literal_xref_scanner
// Tracks constants built in sixteen registers by a Thumb instruction stream
// and flags ADD Rd,Rd,PC sums that hit a target address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item): one instruction per request,
//   with its position, the literal word the feeder fetched for it and a
//   new_search flag that zeroes all tracked values first.
//   Result channel (out_valid/out_stall/out_result): exactly one result per
//   request, in order: hit, hit_register (0 when no hit) and wide.
//   Config port (cfg_wr_en/cfg_index/cfg_wr_data): 0 = target_address,
//   1 = image_size; write only while no request is in flight.
//   An accepted request passes the input register, then decode plus
//   register-file update into the result register, which raises out_valid
//   when it loads. Throughput is one request per cycle while the receiver
//   does not stall; the register file read, the 32-bit add and the
//   target compare all sit in the single decode stage, so dependent instructions
//   follow back to back.
//   When the receiver stalls, the result holds and the input register fills;
//   in_stall then rises until the result is taken.
//   Synchronous reset clears both config registers, all tracked values and
//   both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_literal_xref_scanner (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tlxs_pkg::in_item_t               in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tlxs_pkg::out_item_t                   out_result,
  input  wire logic                             cfg_wr_en,
  input  wire logic [tlxs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_wr_data
);

  logic [31:0]         target_address_r;
  logic [31:0]         image_size_r;
  logic                in_valid_r;
  tlxs_pkg::in_item_t  in_item_r;
  logic                out_valid_r;
  tlxs_pkg::out_item_t out_r;
  tlxs_pkg::out_item_t out_nxt;
  logic [31:0]         tracked_r [tlxs_pkg::NUM_REGS];
  tlxs_pkg::dec_t      dec;
  logic                advance;
  logic                fire;
  logic [31:0]         cur_val;
  logic [31:0]         new_val;

  // Stage handshake
  assign advance   = ~out_valid_r | ~out_stall;
  assign fire      = in_valid_r & advance;
  assign in_stall  = in_valid_r & ~advance;
  assign out_valid = out_valid_r;
  assign out_result = out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_address_r <= '0;
      image_size_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlxs_pkg::CFG_TARGET_ADDRESS: target_address_r <= cfg_wr_data;
        tlxs_pkg::CFG_IMAGE_SIZE:     image_size_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  tlxs_decode u_decode (
    .item       (in_item_r),
    .image_size (image_size_r),
    .dec        (dec)
  );

  // Read the destination, apply the update, compare against the target
  assign cur_val = in_item_r.new_search ? 32'h0 : tracked_r[dec.idx];

  always_comb begin
    unique case (dec.mode)
      tlxs_pkg::UPD_SET: new_val = dec.value;
      tlxs_pkg::UPD_OR:  new_val = cur_val | dec.value;
      tlxs_pkg::UPD_ADD: new_val = cur_val + dec.value;
      default:           new_val = dec.value;
    endcase
    out_nxt.wide         = dec.wide;
    out_nxt.hit          = dec.en && (dec.mode == tlxs_pkg::UPD_ADD)
                           && (new_val == (target_address_r & tlxs_pkg::ADDR_MASK));
    out_nxt.hit_register = out_nxt.hit ? dec.idx : '0;
  end

  // Tracked register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tlxs_pkg::NUM_REGS; i++) begin
        tracked_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < tlxs_pkg::NUM_REGS; i++) begin
        if (dec.en && (dec.idx == tlxs_pkg::REG_IDX_W'(i))) begin
          tracked_r[i] <= new_val;
        end else if (in_item_r.new_search) begin
          tracked_r[i] <= '0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlxs_checker.sv
// ----------------------------------------------------------------------------
// tlxs_checker
// Port-level checks for the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tlxs_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tlxs_pkg::out_item_t out_result
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // With no result waiting, the input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // No register number reported without a hit
  a_hreg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.hit |-> out_result.hit_register == '0)
    else $error("hit_register set without hit");

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A request accepted with no result waiting passes both registers to a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted request");

endmodule

bind thumb_literal_xref_scanner tlxs_checker u_tlxs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the Thumb literal cross-reference scanner with directed instruction
// groups (immediate moves, literal loads, ADD forms) and then with random
// streams built mostly from load-then-ADD-PC sequences aimed at the target.
// Each request is predicted by a local register tracker on acceptance, and
// results are compared field by field, in order, under random stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Narrow three-register ADDS, not used by the block's decode list
  localparam logic [15:0] MSK_ADDS_REG   = 16'hFE00;
  localparam logic [15:0] OP_ADDS_REG    = 16'h1800;
  localparam int          MAX_GAP        = 18;
  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          PHASE_REQUESTS = 116;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tlxs_pkg::in_item_t             in_item = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tlxs_pkg::out_item_t            out_result;
  logic                           cfg_wr_en = 1'b0;
  logic [tlxs_pkg::CFG_IDX_W-1:0] cfg_index = tlxs_pkg::CFG_TARGET_ADDRESS;
  logic [31:0]                    cfg_wr_data = '0;

  // Tracker state and its copy of the configuration
  logic [31:0] reg_values [tlxs_pkg::NUM_REGS] = '{default: '0};
  logic [31:0] target_addr = '0;
  logic [31:0] image_sz = '0;
  tlxs_pkg::out_item_t scan_results_due [$];

  int error_count = 0;
  int requests_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit sender_burst = 1'b0;
  bit receiver_burst = 1'b0;

  thumb_literal_xref_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Instruction tracker
  // ---------------------------------------------------------------------------

  // Thumb modified immediate
  function automatic logic [31:0] thumb_expand_imm(input logic [11:0] imm12);
    logic [7:0]  b;
    logic [31:0] seed;
    logic [63:0] rotated;
    b = imm12[7:0];
    if (imm12[11:10] == 2'b00) begin
      case (imm12[9:8])
        2'd0: return {24'd0, b};
        2'd1: return {8'd0, b, 8'd0, b};
        2'd2: return {b, 8'd0, b, 8'd0};
        default: return {b, b, b, b};
      endcase
    end
    seed = {24'd0, tlxs_pkg::EXP_IMM_TOP | {1'b0, imm12[6:0]}};
    rotated = {seed, seed} >> imm12[11:7];
    return rotated[31:0];
  endfunction

  // Decode one instruction, update the tracked values, return its result
  function automatic tlxs_pkg::out_item_t track_instruction(input tlxs_pkg::in_item_t req);
    logic [15:0] h0, h1;
    logic [31:0] pos, base;
    logic [3:0]  rd2, rd, rn, rm, rt;
    logic [11:0] imm_t;
    logic        h1ok, is_add, is_ldr_n, is_ldr_w;
    longint      off, disp, lim;
    tlxs_pkg::out_item_t res;
    h0 = req.first_halfword;
    h1 = req.second_halfword;
    pos = req.position & tlxs_pkg::ADDR_MASK;
    res = '0;
    if (req.new_search) begin
      foreach (reg_values[i]) reg_values[i] = '0;
    end
    res.wide = (h0[15:13] == 3'b111) && (h0[12:11] != 2'b00);
    h1ok = !h1[15];
    rd2 = h1[11:8];
    imm_t = {h0[10], h1[14:12], h1[7:0]};
    is_ldr_n = (h0 & tlxs_pkg::MSK_NARROW5) == tlxs_pkg::OP_LDR_LIT_N;
    is_ldr_w = (h0 & tlxs_pkg::MSK_LDR_W) == tlxs_pkg::OP_LDR_LIT_W;

    if ((h0 & tlxs_pkg::MSK_NARROW5) == tlxs_pkg::OP_MOVS_IMM8) begin
      reg_values[{1'b0, h0[10:8]}] = {24'd0, h0[7:0]};
    end else if ((h0 & tlxs_pkg::MSK_MOV_W) == tlxs_pkg::OP_MOV_W && h1ok) begin
      reg_values[rd2] = thumb_expand_imm(imm_t);
    end else if ((h0 & tlxs_pkg::MSK_MOVW_T) == tlxs_pkg::OP_MOVW && h1ok) begin
      reg_values[rd2] = {16'd0, h0[3:0], imm_t};
    end else if (is_ldr_n || is_ldr_w) begin
      // literal address from the word-aligned PC
      base = (pos + 32'd4) & 32'hFFFF_FFFC;
      off = {32'd0, base};
      if (is_ldr_n) begin
        rt = {1'b0, h0[10:8]};
        disp = {h0[7:0], 2'b00};
        off = off + disp;
      end else begin
        rt = h1[15:12];
        disp = h1[11:0];
        off = h0[7] ? off + disp : off - disp;
      end
      lim = {32'd0, image_sz & tlxs_pkg::ADDR_MASK};
      if (off >= 0 && off + 4 <= lim) reg_values[rt] = req.literal_word;
    end else if ((h0 & tlxs_pkg::MSK_MOVW_T) == tlxs_pkg::OP_MOVT && h1ok) begin
      reg_values[rd2] = reg_values[rd2] | {h0[3:0], imm_t, 16'd0};
    end else begin
      is_add = 1'b1;
      rd = '0;
      rn = '0;
      rm = '0;
      if ((h0 & MSK_ADDS_REG) == OP_ADDS_REG) begin
        rd = {1'b0, h0[2:0]};
        rn = {1'b0, h0[5:3]};
        rm = {1'b0, h0[8:6]};
      end else if ((h0 & tlxs_pkg::MSK_ADD_HI) == tlxs_pkg::OP_ADD_HI) begin
        rd = {h0[7], h0[2:0]};
        rn = rd;
        rm = h0[6:3];
      end else if ((h0 & tlxs_pkg::MSK_ADD_W) == tlxs_pkg::OP_ADD_W) begin
        rd = rd2;
        rn = h0[3:0];
        rm = h1[3:0];
      end else begin
        is_add = 1'b0;
      end
      // ADD Rd, Rd, PC accumulates and may land on the target
      if (is_add && rm == tlxs_pkg::REG_PC && rn == rd) begin
        reg_values[rd] = reg_values[rd] + pos + 32'd4;
        if (reg_values[rd] == (target_addr & tlxs_pkg::ADDR_MASK)) begin
          res.hit = 1'b1;
          res.hit_register = rd;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoders, each returning {first_halfword, second_halfword}
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_movs(input logic [2:0] rd, input logic [7:0] imm8);
    return {tlxs_pkg::OP_MOVS_IMM8 | {5'd0, rd, imm8}, 16'($urandom)};
  endfunction

  function automatic logic [31:0] enc_mov_w(input logic [3:0] rd, input logic [11:0] imm12);
    logic [15:0] h0;
    h0 = tlxs_pkg::OP_MOV_W | {5'd0, imm12[11], 5'd0, 1'($urandom), 4'd0};
    return {h0, 1'b0, imm12[10:8], rd, imm12[7:0]};
  endfunction

  // MOVW and MOVT share a layout
  function automatic logic [31:0] enc_imm16(input logic [15:0] op, input logic [3:0] rd,
                                            input logic [15:0] imm16);
    logic [15:0] h0;
    h0 = op | {5'd0, imm16[11], 6'd0, imm16[15:12]};
    return {h0, 1'b0, imm16[10:8], rd, imm16[7:0]};
  endfunction

  function automatic logic [31:0] enc_ldr_n(input logic [2:0] rt, input logic [7:0] imm8);
    return {tlxs_pkg::OP_LDR_LIT_N | {5'd0, rt, imm8}, 16'($urandom)};
  endfunction

  function automatic logic [31:0] enc_ldr_w(input logic [3:0] rt, input logic up,
                                            input logic [11:0] imm12);
    return {tlxs_pkg::OP_LDR_LIT_W | {8'd0, up, 7'd0}, rt, imm12};
  endfunction

  function automatic logic [31:0] enc_add_hi(input logic [3:0] rd, input logic [3:0] rm);
    return {tlxs_pkg::OP_ADD_HI | {8'd0, rd[3], rm, rd[2:0]}, 16'($urandom)};
  endfunction

  // shift and flag bits are don't-care for the tracker
  function automatic logic [31:0] enc_add_w(input logic [3:0] rd, input logic [3:0] rn,
                                            input logic [3:0] rm);
    logic [15:0] h0;
    h0 = tlxs_pkg::OP_ADD_W | {11'd0, 1'($urandom), rn};
    return {h0, 4'($urandom), rd, 4'($urandom), rm};
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_instr(input logic [31:0] enc, input logic [31:0] pos,
                            input logic [31:0] lit, input logic fresh);
    tlxs_pkg::in_item_t req;
    int                 gap;
    req.first_halfword = enc[31:16];
    req.second_halfword = enc[15:0];
    req.position = pos;
    req.literal_word = lit;
    req.new_search = fresh;
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_stall);
    scan_results_due.push_back(track_instruction(req));
    requests_sent++;
  endtask

  // Hold off until every result is back and the pipe is empty
  task automatic settle_pipeline();
    @(negedge clk) in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [tlxs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(negedge clk) cfg_wr_en <= 1'b0;
    if (idx == tlxs_pkg::CFG_TARGET_ADDRESS) target_addr = data;
    else image_sz = data;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall and in-order check
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    tlxs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = scan_results_due.pop_front();
        if (out_result.hit !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", out_result.hit, want.hit));
        if (out_result.hit_register !== want.hit_register)
          report_mismatch($sformatf("hit_register got %0d want %0d",
                                    out_result.hit_register, want.hit_register));
        if (out_result.wide !== want.wide)
          report_mismatch($sformatf("wide got %b want %b", out_result.wide, want.wide));
      end
      if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
      stall_left = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  always @(negedge clk) out_stall <= (stall_left != 0);

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // MOVS, MOV.W expansion patterns, MOVW/MOVT then a hit
  task automatic test_immediate_forms();
    write_register(tlxs_pkg::CFG_TARGET_ADDRESS, 32'h1235_0103);
    write_register(tlxs_pkg::CFG_IMAGE_SIZE, 32'h0000_1000);
    send_instr(enc_movs(3'd0, 8'h00), 32'h0, $urandom, 1'b0);
    send_instr(enc_movs(3'd7, 8'hFF), 32'h2, $urandom, 1'b1);
    send_instr(enc_mov_w(4'd1, 12'h0FF), 32'h4, $urandom, 1'b0);
    send_instr(enc_mov_w(4'd3, 12'h1AB), 32'h8, $urandom, 1'b0);
    send_instr(enc_mov_w(4'd4, 12'h2CD), 32'hC, $urandom, 1'b0);
    send_instr(enc_mov_w(4'd14, 12'h3FF), 32'h10, $urandom, 1'b0);
    send_instr(enc_mov_w(4'd15, 12'hC7F), 32'h14, $urandom, 1'b0);
    send_instr(enc_mov_w(4'd6, 12'h400), 32'h18, $urandom, 1'b0);
    // 0x1234FFFF + 0x104 reaches the target
    send_instr(enc_imm16(tlxs_pkg::OP_MOVW, 4'd2, 16'hFFFF), 32'h1C, $urandom, 1'b0);
    send_instr(enc_imm16(tlxs_pkg::OP_MOVT, 4'd2, 16'h1234), 32'h20, $urandom, 1'b0);
    send_instr(enc_add_hi(4'd2, tlxs_pkg::REG_PC), 32'h100, $urandom, 1'b0);
  endtask

  // Literal range check: inside, both edges, negative, past the end
  task automatic test_literal_loads();
    send_instr(enc_ldr_n(3'd3, 8'hFF), 32'h10, 32'hDEAD_BEEF, 1'b0);
    send_instr(enc_ldr_w(4'd12, 1'b1, 12'hFFF), 32'hFFE, 32'h1111_1111, 1'b0);
    send_instr(enc_ldr_w(4'd11, 1'b0, 12'h014), 32'h10, 32'h1234_0000, 1'b0);
    send_instr(enc_ldr_w(4'd10, 1'b0, 12'h018), 32'h12, 32'h2222_2222, 1'b0);
    // odd position, last word of the image, then one word past it
    send_instr(enc_ldr_n(3'd4, 8'h00), 32'hFF9, 32'h3333_3333, 1'b0);
    send_instr(enc_ldr_n(3'd5, 8'h01), 32'hFF9, 32'h4444_4444, 1'b0);
    send_instr(enc_add_w(4'd11, 4'd11, tlxs_pkg::REG_PC), 32'h0001_00FF, $urandom, 1'b0);
  endtask

  // ADD forms that must and must not accumulate
  task automatic test_add_forms();
    settle_pipeline();
    write_register(tlxs_pkg::CFG_TARGET_ADDRESS, 32'hFFFF_FFFF);
    send_instr(enc_imm16(tlxs_pkg::OP_MOVW, 4'd8, 16'hFFF0), 32'h0, $urandom, 1'b0);
    send_instr(enc_imm16(tlxs_pkg::OP_MOVT, 4'd8, 16'hFFFF), 32'h4, $urandom, 1'b0);
    send_instr(enc_add_w(4'd8, 4'd8, tlxs_pkg::REG_PC), 32'hB, $urandom, 1'b0);
    send_instr(enc_add_w(4'd9, 4'd8, tlxs_pkg::REG_PC), 32'hB, $urandom, 1'b0);
    send_instr(enc_add_hi(4'd5, 4'd4), 32'hC, $urandom, 1'b0);
    send_instr({OP_ADDS_REG | {7'd0, 3'd7, 3'd1, 3'd1}, 16'hFFFF}, 32'hE, $urandom, 1'b0);
    send_instr(enc_add_hi(4'd15, tlxs_pkg::REG_PC), 32'hFFFF_FFFE, $urandom, 1'b1);
  endtask

  // Load a value, then ADD Rd,Rd,PC from the position that hits the target
  task automatic send_hit_sequence();
    logic [3:0]  r;
    logic [11:0] imm12;
    logic [31:0] need, pos_add, pos_ld, val;
    logic        fresh;
    r = 4'($urandom);
    fresh = ($urandom_range(0, 7) == 0);
    pos_add = $urandom;
    need = target_addr - pos_add - 32'd4;
    case ($urandom_range(0, 2))
      0: begin
        send_instr(enc_imm16(tlxs_pkg::OP_MOVW, r, need[15:0]), $urandom, $urandom, fresh);
        send_instr(enc_imm16(tlxs_pkg::OP_MOVT, r, need[31:16]), $urandom, $urandom, 1'b0);
      end
      1: begin
        // keep the literal inside the image when it is big enough
        pos_ld = (image_sz >= 32'h3000) ?
                 $urandom_range(32'h1000, image_sz - 32'h1010) : $urandom;
        if (r < 4'd8 && $urandom_range(0, 1) == 1)
          send_instr(enc_ldr_n(r[2:0], 8'($urandom)), pos_ld, need, fresh);
        else
          send_instr(enc_ldr_w(r, 1'($urandom), 12'($urandom)), pos_ld, need, fresh);
      end
      default: begin
        if (r < 4'd8 && $urandom_range(0, 1) == 1) begin
          val = $urandom_range(0, 255);
          send_instr(enc_movs(r[2:0], val[7:0]), $urandom, $urandom, fresh);
        end else begin
          imm12 = 12'($urandom);
          val = thumb_expand_imm(imm12);
          send_instr(enc_mov_w(r, imm12), $urandom, $urandom, fresh);
        end
        pos_add = target_addr - val - 32'd4;
      end
    endcase
    if ($urandom_range(0, 1) == 1)
      send_instr(enc_add_hi(r, tlxs_pkg::REG_PC), pos_add, $urandom, 1'b0);
    else
      send_instr(enc_add_w(r, r, tlxs_pkg::REG_PC), pos_add, $urandom, 1'b0);
  endtask

  // Near misses: corrupted MOVW, wrong Rn or Rm, clear right before the ADD
  task automatic send_broken_sequence();
    logic [3:0]  r, other;
    logic [31:0] enc, pos;
    r = 4'($urandom);
    other = r ^ 4'($urandom_range(1, 15));
    pos = $urandom;
    enc = enc_imm16(tlxs_pkg::OP_MOVW, r, 16'(target_addr - pos - 32'd4));
    if ($urandom_range(0, 3) == 0) enc[15] = 1'b1;
    send_instr(enc, $urandom, $urandom, 1'b0);
    case ($urandom_range(0, 3))
      0: send_instr(enc_add_w(r, other, tlxs_pkg::REG_PC), pos, $urandom, 1'b0);
      1: send_instr(enc_add_hi(r, other), pos, $urandom, 1'b0);
      2: send_instr(enc_add_w(r, r, other), pos, $urandom, 1'b0);
      default: send_instr(enc_add_hi(r, tlxs_pkg::REG_PC), pos, $urandom, 1'b1);
    endcase
  endtask

  // Random phases across target and image size settings
  task automatic test_random_stream();
    logic [31:0] phase_target [5];
    logic [31:0] phase_image [5];
    int          phase_end;
    phase_target = '{$urandom, $urandom, 32'h0, 32'hFFFF_FFFF, $urandom};
    phase_image = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h3, $urandom};
    for (int p = 0; p < 5; p++) begin
      settle_pipeline();
      write_register(tlxs_pkg::CFG_TARGET_ADDRESS, phase_target[p]);
      write_register(tlxs_pkg::CFG_IMAGE_SIZE, phase_image[p]);
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 59) == 0) settle_pipeline();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_hit_sequence();
          8: send_broken_sequence();
          default: send_instr($urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_immediate_forms();
    test_literal_loads();
    test_add_forms();
    test_random_stream();
    settle_pipeline();
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
